// File: design/tlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared types and constants for the type-length-payload deframer.
// ----------------------------------------------------------------------------
package tlpd_pkg;

    localparam int unsigned MAX_DIGITS_DEF = 9;
    localparam int unsigned LEN_W          = 30;
    localparam int unsigned CNT_W          = 4;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_CODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 2'd2;

    localparam logic [7:0]       ENDPOINT_CODE_RST = 8'd1;
    localparam logic [7:0]       RAW_CODE_RST      = 8'd2;
    localparam logic [CNT_W-1:0] DIGIT_COUNT_RST   = 4'd9;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BADTYPE  = 2'd2,
        ST_BADDIGIT = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ENDPOINT = 1'b0,
        KIND_RAW      = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0]       endpoint_code;
        logic [7:0]       raw_code;
        logic [CNT_W-1:0] digit_count;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        t_kind      kind;
        logic [7:0] payload;
        logic       last;
    } t_result;

endpackage

// File: design/tlpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_if
// Valid/ready channels of the deframer: received bytes, results, register
// writes.
// ----------------------------------------------------------------------------
interface tlpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlpd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_status;
    logic       message_kind;
    logic [7:0] payload_byte;
    logic       last_of_message;

    modport source (output valid, output out_status, output message_kind,
                    output payload_byte, output last_of_message, input ready);
    modport sink   (input valid, input out_status, input message_kind,
                    input payload_byte, input last_of_message, output ready);
endinterface

interface tlpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// File: design/type_length_payload_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// type_length_payload_deframer_core
// Byte-stream deframer for type / ASCII length / payload frames.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and gives at most one result per byte.
// The frame state updates at the cycle a byte is accepted, and the result
// lands in a two-entry output buffer, so a byte enters every cycle as long
// as the result side keeps up; i_rx.ready drops only while both buffer
// entries hold untaken results. Each result is registered in that buffer
// before it shows on o_res. Register writes are taken at any time, ready is
// always high; the digit count is sampled when a type byte is accepted.
// ----------------------------------------------------------------------------
module type_length_payload_deframer_core
    import tlpd_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlpd_rx_if.sink    i_rx,
    tlpd_res_if.source o_res,
    tlpd_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_result fsm_res;
    t_result buf_res;
    logic    fsm_res_valid;
    logic    buf_space;
    logic    rx_accept;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = buf_space;
    assign rx_accept   = i_rx.valid && buf_space;

    tlpd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.cfg_index),
        .i_wr_data  (i_cfg.cfg_data),
        .o_cfg      (cfg)
    );

    tlpd_frame_fsm #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_frame_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_byte      (i_rx.rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (fsm_res_valid),
        .o_res       (fsm_res)
    );

    tlpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_accept && fsm_res_valid),
        .i_data  (fsm_res),
        .o_space (buf_space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (buf_res)
    );

    assign o_res.out_status      = buf_res.status;
    assign o_res.message_kind    = buf_res.kind;
    assign o_res.payload_byte    = buf_res.payload;
    assign o_res.last_of_message = buf_res.last;

endmodule

// File: design/tlpd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_cfg_regs
// Configuration registers: type codes and length digit count.
// ----------------------------------------------------------------------------
module tlpd_cfg_regs
    import tlpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.endpoint_code <= ENDPOINT_CODE_RST;
            r_cfg.raw_code      <= RAW_CODE_RST;
            r_cfg.digit_count   <= DIGIT_COUNT_RST;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                REG_ENDPOINT_CODE: r_cfg.endpoint_code <= i_wr_data;
                REG_RAW_CODE:      r_cfg.raw_code      <= i_wr_data;
                REG_DIGIT_COUNT:   r_cfg.digit_count   <= i_wr_data[CNT_W-1:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/tlpd_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_frame_fsm
// Frame parser: type byte, ASCII length digits, payload count-down.
// ----------------------------------------------------------------------------
module tlpd_frame_fsm
    import tlpd_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int unsigned DW = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    t_phase           r_phase,  n_phase;
    t_kind            r_kind,   n_kind;
    logic [DW-1:0]    r_digits, n_digits;
    logic [LEN_W-1:0] r_len,    n_len;

    logic             is_digit;
    logic [LEN_W-1:0] len_acc;
    logic [DW-1:0]    digits_dec;
    logic [CNT_W-1:0] cnt_clamped;
    logic             match_ep;
    logic             match_raw;

    always_comb begin
        is_digit   = (i_byte >= ASCII_ZERO) && (i_byte <= ASCII_NINE);
        // len * 10 + digit, kept to the field width
        len_acc    = (r_len << 3) + (r_len << 1)
                   + LEN_W'(i_byte - ASCII_ZERO);
        digits_dec = r_digits - DW'(1);
        match_ep   = (i_byte == i_cfg.endpoint_code);
        match_raw  = (i_byte == i_cfg.raw_code);
        if (i_cfg.digit_count == '0) begin
            cnt_clamped = CNT_W'(1);
        end else if (i_cfg.digit_count > MAX_CNT) begin
            cnt_clamped = MAX_CNT;
        end else begin
            cnt_clamped = i_cfg.digit_count;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_digits    = r_digits;
        n_len       = r_len;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_PAYLOAD, kind: r_kind, payload: 8'd0, last: 1'b0};
        unique case (r_phase)
            PH_LEN: begin
                if (!is_digit) begin
                    n_phase      = PH_TYPE;
                    o_res_valid  = 1'b1;
                    o_res.status = ST_BADDIGIT;
                end else begin
                    n_len    = len_acc;
                    n_digits = digits_dec;
                    if (digits_dec == '0) begin
                        if (len_acc == '0) begin
                            n_phase      = PH_TYPE;
                            o_res_valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                            o_res.last   = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                o_res_valid   = 1'b1;
                o_res.payload = i_byte;
                if (r_len <= LEN_W'(1)) begin
                    o_res.last = 1'b1;
                    n_len      = '0;
                    n_phase    = PH_TYPE;
                end else begin
                    n_len = r_len - LEN_W'(1);
                end
            end
            default: begin
                n_phase = PH_TYPE;
                if (match_ep || match_raw) begin
                    n_kind   = match_ep ? KIND_ENDPOINT : KIND_RAW;
                    n_digits = DW'(cnt_clamped);
                    n_len    = '0;
                    n_phase  = PH_LEN;
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_BADTYPE;
                    o_res.kind   = KIND_ENDPOINT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_kind   <= KIND_ENDPOINT;
            r_digits <= '0;
            r_len    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_digits <= n_digits;
            r_len    <= n_len;
        end
    end

endmodule

// File: design/tlpd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_out_buf
// Two-entry result buffer; ready toward the parser comes from registers only.
// ----------------------------------------------------------------------------
module tlpd_out_buf
    import tlpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: tb/type_length_payload_deframer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// type_length_payload_deframer_core_test
// Self-checking bench for the type / ASCII length / payload deframer. A
// byte queue feeds a bursty sender, a predictor tracks the frame state for
// every accepted byte, and a monitor that stalls on a rotating ready pattern
// compares each result field by field against the oldest expected one.
// Registers change only between runs of bytes, once all results are in.
// ----------------------------------------------------------------------------
module type_length_payload_deframer_core_test;
    import tlpd_pkg::*;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PRINT_LIMIT   = 40;
    localparam int unsigned PHASE_ITEMS   = 250;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {FR_WAIT_TYPE, FR_LENGTH, FR_PAYLOAD} t_frame_phase;
    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} t_pace;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tlpd_rx_if  rx_ch();
    tlpd_res_if res_ch();
    tlpd_cfg_if cfg_ch();

    type_length_payload_deframer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // register copies
    logic [7:0]       endpoint_code = ENDPOINT_CODE_RST;
    logic [7:0]       raw_code      = RAW_CODE_RST;
    logic [CNT_W-1:0] digit_count   = DIGIT_COUNT_RST;

    // frame tracking
    t_frame_phase     frame_phase = FR_WAIT_TYPE;
    t_kind            frame_kind  = KIND_ENDPOINT;
    logic [CNT_W-1:0] digits_left = '0;
    logic [LEN_W-1:0] bytes_left  = '0;

    logic [7:0] rx_bytes_pending[$];
    t_result    expected_results[$];

    t_pace       send_pace     = PACE_FULL;
    t_pace       recv_pace     = PACE_FULL;
    int          burst_left    = 0;
    int          gap_left      = 0;
    logic [31:0] ready_pattern = '1;
    int          pattern_pos   = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // append one byte to the send queue
    function automatic void queue_byte(input logic [7:0] b);
        rx_bytes_pending = {rx_bytes_pending, b};
    endfunction

    // append one result to the expected queue
    function automatic void expect_result(input t_result r);
        expected_results = {expected_results, r};
    endfunction

    function automatic t_result make_result(input t_status st, input t_kind k,
                                            input logic [7:0] data, input logic last);
        t_result r;
        r.status  = st;
        r.kind    = k;
        r.payload = data;
        r.last    = last;
        return r;
    endfunction

    // advance the frame state by one accepted byte, queue its result if any
    task automatic deframe_byte(input logic [7:0] b);
        int unsigned n;
        case (frame_phase)
            FR_LENGTH: begin
                if (b < ASCII_ZERO || b > ASCII_NINE) begin
                    frame_phase = FR_WAIT_TYPE;
                    expect_result(make_result(ST_BADDIGIT, frame_kind, 8'h00, 1'b0));
                end else begin
                    bytes_left  = LEN_W'(bytes_left * 10 + (b - ASCII_ZERO));
                    digits_left = digits_left - 1'b1;
                    if (digits_left == 0) begin
                        if (bytes_left == 0) begin
                            frame_phase = FR_WAIT_TYPE;
                            expect_result(make_result(ST_EMPTY, frame_kind, 8'h00, 1'b1));
                        end else begin
                            frame_phase = FR_PAYLOAD;
                        end
                    end
                end
            end
            FR_PAYLOAD: begin
                expect_result(make_result(ST_PAYLOAD, frame_kind, b, bytes_left <= 1));
                if (bytes_left <= 1) begin
                    bytes_left  = '0;
                    frame_phase = FR_WAIT_TYPE;
                end else begin
                    bytes_left = bytes_left - 1'b1;
                end
            end
            default: begin
                if (b == endpoint_code || b == raw_code) begin
                    n = digit_count;
                    if (n == 0) n = 1;
                    if (n > MAX_DIGITS_DEF) n = MAX_DIGITS_DEF;
                    // endpoint wins when both codes match
                    frame_kind  = (b == endpoint_code) ? KIND_ENDPOINT : KIND_RAW;
                    digits_left = n[CNT_W-1:0];
                    bytes_left  = '0;
                    frame_phase = FR_LENGTH;
                end else begin
                    expect_result(make_result(ST_BADTYPE, KIND_ENDPOINT, 8'h00, 1'b0));
                end
            end
        endcase
    endtask

    // sender: bursts of random length, random gaps between them (no gaps at full pace)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                deframe_byte(rx_ch.rx_byte);
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (gap_left > 0 || rx_bytes_pending.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    rx_ch.valid <= 1'b0;
                end else begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_bytes_pending[0];
                    rx_bytes_pending.delete(0);
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0 && send_pace != PACE_FULL) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = (send_pace == PACE_HEAVY) ? $urandom_range(1, 8)
                                                               : $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    // receiver: check accepted results, stall on a rotating ready pattern
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            pattern_pos = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: status %0d byte %02h",
                                              res_ch.out_status, res_ch.payload_byte));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (res_ch.out_status !== want.status)
                        report_mismatch($sformatf("out_status got %0d want %0d",
                                                  res_ch.out_status, want.status));
                    if (res_ch.message_kind !== want.kind)
                        report_mismatch($sformatf("message_kind got %0d want %0d",
                                                  res_ch.message_kind, want.kind));
                    if (res_ch.payload_byte !== want.payload)
                        report_mismatch($sformatf("payload_byte got %02h want %02h",
                                                  res_ch.payload_byte, want.payload));
                    if (res_ch.last_of_message !== want.last)
                        report_mismatch($sformatf("last_of_message got %0d want %0d",
                                                  res_ch.last_of_message, want.last));
                end
            end
            if (pattern_pos == 0) begin
                case (recv_pace)
                    PACE_FULL:  ready_pattern = '1;
                    PACE_LIGHT: ready_pattern = $urandom | $urandom;
                    default:    ready_pattern = $urandom & $urandom;
                endcase
            end
            res_ch.ready <= ready_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 32;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("type_length_payload_deframer_core_test: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.cfg_index <= idx;
        cfg_ch.cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_ENDPOINT_CODE: endpoint_code = data;
            REG_RAW_CODE:      raw_code      = data;
            REG_DIGIT_COUNT:   digit_count   = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] ep, input logic [7:0] raw,
                              input logic [7:0] count_data);
        write_reg(REG_ENDPOINT_CODE, ep);
        write_reg(REG_RAW_CODE, raw);
        write_reg(REG_DIGIT_COUNT, count_data);
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // hold until every byte is in and every result is out, then let it settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (rx_bytes_pending.size() != 0 || rx_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // queue one frame; a break position below n_digits cuts the length field
    task automatic queue_frame(input logic [7:0] type_byte, input int unsigned n_digits,
                               input longint unsigned len, input int break_at,
                               input logic [7:0] bad_char);
        longint unsigned scale;
        scale = 1;
        repeat (n_digits - 1) scale *= 10;
        queue_byte(type_byte);
        for (int i = 0; i < n_digits; i++) begin
            if (i == break_at) begin
                queue_byte(bad_char);
                return;
            end
            queue_byte(ASCII_ZERO + 8'((len / scale) % 10));
            scale /= 10;
        end
        repeat (len) queue_byte(8'($urandom));
    endtask

    task automatic run_random_phase(input logic [7:0] ep, input logic [7:0] raw,
                                    input logic [7:0] count_data, input t_pace sp,
                                    input t_pace rp);
        int unsigned     eff;
        int unsigned     pick;
        longint unsigned max_len;
        longint unsigned cap;
        longint unsigned len;
        logic [7:0]      b;
        logic [7:0]      type_byte;
        wait_drained();
        set_config(ep, raw, count_data);
        @(negedge i_clk);
        send_pace = sp;
        recv_pace = rp;
        eff = count_data[CNT_W-1:0];
        if (eff == 0) eff = 1;
        if (eff > MAX_DIGITS_DEF) eff = MAX_DIGITS_DEF;
        max_len = 1;
        repeat (eff) max_len *= 10;
        max_len -= 1;
        while (rx_bytes_pending.size() < PHASE_ITEMS) begin
            pick      = $urandom_range(0, 99);
            type_byte = $urandom_range(0, 1) ? raw_code : endpoint_code;
            if (pick < 8) begin
                // stray byte that cannot open a frame
                do b = 8'($urandom); while (b == endpoint_code || b == raw_code);
                queue_byte(b);
            end else if (pick < 20) begin
                case ($urandom_range(0, 3))
                    0:       b = ASCII_ZERO - 8'd1;
                    1:       b = ASCII_NINE + 8'd1;
                    default: do b = 8'($urandom); while (b >= ASCII_ZERO && b <= ASCII_NINE);
                endcase
                queue_frame(type_byte, eff, $urandom_range(0, 32'(max_len)),
                            $urandom_range(0, eff - 1), b);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15) cap = 0;
                else if (pick < 80) cap = 8;
                else if (pick < 97) cap = 60;
                else cap = 250;
                if (cap > max_len) cap = max_len;
                len = (cap == 0) ? 0 : $urandom_range(1, 32'(cap));
                queue_frame(type_byte, eff, len, -1, 8'h00);
            end
        end
    endtask

    initial begin
        cfg_ch.valid     <= 1'b0;
        cfg_ch.cfg_index <= REG_ENDPOINT_CODE;
        cfg_ch.cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset codes: bad types at both byte extremes, empty endpoint frame,
        // raw frame cut mid-length by the byte below '0'
        send_pace = PACE_LIGHT;
        recv_pace = PACE_LIGHT;
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_frame(ENDPOINT_CODE_RST, MAX_DIGITS_DEF, 0, -1, 8'h00);
        queue_frame(RAW_CODE_RST, MAX_DIGITS_DEF, 0, 4, ASCII_ZERO - 8'd1);

        // one digit: raw single-byte payload, then endpoint cut by the byte above '9'
        wait_drained();
        set_config(ENDPOINT_CODE_RST, RAW_CODE_RST, 8'd1);
        @(negedge i_clk);
        queue_byte(RAW_CODE_RST);
        queue_byte(ASCII_ZERO + 8'd1);
        queue_byte(8'hFF);
        queue_frame(ENDPOINT_CODE_RST, 1, 0, 0, ASCII_NINE + 8'd1);

        run_random_phase(ENDPOINT_CODE_RST, RAW_CODE_RST, 8'd9, PACE_LIGHT, PACE_LIGHT);
        run_random_phase(8'h00, 8'hFF, 8'd1, PACE_FULL, PACE_FULL);
        // count of zero acts as one
        run_random_phase(8'hFF, 8'h00, 8'd0, PACE_HEAVY, PACE_LIGHT);
        // both codes equal: every frame is an endpoint frame
        run_random_phase(8'h5A, 8'h5A, 8'd2, PACE_LIGHT, PACE_HEAVY);
        // digit type codes, count above the maximum clamps to it
        run_random_phase(ASCII_ZERO, ASCII_NINE, 8'h0F, PACE_HEAVY, PACE_HEAVY);
        run_random_phase(8'($urandom), 8'($urandom), 8'd3, PACE_LIGHT, PACE_LIGHT);
        // upper data bits are dropped by the count register
        run_random_phase(8'h80, 8'h7F, 8'hF4, PACE_FULL, PACE_HEAVY);

        wait_drained();
        if (error_count == 0) begin
            $display("type_length_payload_deframer_core_test: done, clean");
        end else begin
            $display("type_length_payload_deframer_core_test: done, errors");
        end
        $finish;
    end

endmodule
